[hdl/bpa_pkg.sv]
// Package for the bitmap page allocator: request and response beats, codes and defaults.
package bpa_pkg;

  localparam int NUM_PAGES_DEF     = 65536;
  localparam int WORD_BITS_DEF     = 64;
  localparam int PAGE_W            = 16;
  localparam int COUNT_W           = 17;
  localparam int RESULT_PAGE_LIMIT = 65536;

  localparam logic [1:0] REQ_ALLOC     = 2'd0;
  localparam logic [1:0] REQ_FREE      = 2'd1;
  localparam logic [1:0] REQ_MARK_FREE = 2'd2;
  localparam logic [1:0] REQ_MARK_USED = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [PAGE_W-1:0]  page_index;
    logic [COUNT_W-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] result_page;
    logic [1:0]        status;
  } rsp_t;

endpackage

[hdl/bitmap_page_allocator.sv]
// Allocate walks the bitmap words from word 0, writes the hit word back in S_AWR, then loads the result in S_FIN.
// Free and range requests first split the page number into word and bit in S_DIV (a shift for a
// power-of-two WORD_BITS, else a reciprocal multiply), then walk and write back the words of the range.
// One request at a time; the walk is paced by the single bitmap memory, one word read per cycle, and
// a finished result waits in S_FIN while the previous beat is held by out_stall.
// After reset a clearing pass writes every one of the NUM_WORDS words (1024 by default) to all ones.
module bitmap_page_allocator #(
  parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
  parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bpa_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bpa_pkg::rsp_t out_data
);

  localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int EW        = ($clog2(NUM_PAGES + 1) > 18) ? $clog2(NUM_PAGES + 1) : 18;
  localparam int PGW       = EW + 1;
  localparam int LIMIT     = (NUM_PAGES < bpa_pkg::RESULT_PAGE_LIMIT) ?
                             NUM_PAGES : bpa_pkg::RESULT_PAGE_LIMIT;
  localparam bit WB_POW2   = ((WORD_BITS & (WORD_BITS - 1)) == 0);
  localparam int PW        = bpa_pkg::PAGE_W;
  localparam int MW        = PW + 1;
  localparam int DIV_SH    = PW + BW;
  localparam int DIV_M     = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_AWR  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        init_addr_r;

  logic [1:0]           kind_r;
  logic [PW-1:0]        first_r;
  logic [PGW-1:0]       end_r;
  logic [1:0]           status_r;
  logic [PW-1:0]        page_r;

  logic                 div_cnt_r;
  logic [PW-1:0]        div_q_r;

  logic [AW-1:0]        rd_addr_r, first_word_r;
  logic [PGW-1:0]       rd_base_r;
  logic [BW-1:0]        first_bit_r;
  logic                 d_valid_r;
  logic [AW-1:0]        d_addr_r;
  logic [PGW-1:0]       d_base_r;

  logic [WORD_BITS-1:0] hit_word_r, hit_free_r;
  logic [AW-1:0]        hit_addr_r;
  logic [PW-1:0]        hit_base_r;

  logic                 out_valid_r;
  bpa_pkg::rsp_t        out_data_r;

  logic                 in_acc, out_load;
  logic [EW-1:0]        req_sum;
  logic [PGW-1:0]       req_end;
  logic                 more_words, issue, found, walk_done;
  logic [PGW-1:0]       remaining;
  logic [WORD_BITS-1:0] ones, hi_mask, lo_mask, range_mask, free_bits, alloc_iso;
  logic [BW-1:0]        alloc_bit;
  logic [PW+MW-1:0]     div_prod;
  logic [PW-1:0]        div_quo, div_back;
  logic                 div_done;
  logic [PW-1:0]        q_fin;
  logic [BW-1:0]        rem_fin;

  assign ones     = '1;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // A single free is a range of one page being cleared.
  always_comb begin
    if (in_data.req_type == bpa_pkg::REQ_FREE) begin
      req_sum = EW'(in_data.page_index) + EW'(1);
    end else begin
      req_sum = EW'(in_data.page_index) + EW'(in_data.page_count);
    end
    req_end = (req_sum > EW'(NUM_PAGES)) ? PGW'(NUM_PAGES) : PGW'(req_sum);
  end

  // Page to word and bit: shift for power-of-two WORD_BITS, else reciprocal multiply, then remainder.
  assign div_prod = {{MW{1'b0}}, first_r} * {{PW{1'b0}}, MW'(DIV_M)};
  assign div_quo  = PW'(div_prod >> DIV_SH);
  assign div_back = first_r - div_q_r * PW'(WORD_BITS);
  assign q_fin    = WB_POW2 ? (first_r >> BW) : div_q_r;
  assign rem_fin  = WB_POW2 ? first_r[BW-1:0] : div_back[BW-1:0];
  assign div_done = WB_POW2 || div_cnt_r;

  // Walk: one word read per cycle; ranges modify and write back on the cycle the data lands.
  assign remaining  = end_r - d_base_r;
  assign hi_mask    = (remaining >= PGW'(WORD_BITS)) ? ones : ~(ones << remaining[BW-1:0]);
  assign lo_mask    = (d_addr_r == first_word_r) ? (ones << first_bit_r) : ones;
  assign range_mask = hi_mask & lo_mask;
  assign free_bits  = ~rd_data_r & hi_mask;
  assign found      = (state_r == S_WALK) && (kind_r == bpa_pkg::REQ_ALLOC) && d_valid_r &&
                      (|free_bits);
  assign more_words = (rd_base_r < end_r);
  assign issue      = (state_r == S_WALK) && more_words && !found;
  assign walk_done  = !more_words && !d_valid_r;

  // Lowest free bit of the hit word.
  assign alloc_iso = hit_free_r & (~hit_free_r + WORD_BITS'(1));
  always_comb begin
    alloc_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (alloc_iso[i]) begin
        alloc_bit = alloc_bit | BW'(i);
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = d_addr_r;
    mem_wdata = rd_data_r & ~range_mask;
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr_r;
        mem_wdata = ones;
      end
      S_WALK: begin
        mem_we = d_valid_r && (kind_r != bpa_pkg::REQ_ALLOC);
        if (kind_r == bpa_pkg::REQ_MARK_USED) begin
          mem_wdata = rd_data_r | range_mask;
        end
      end
      S_AWR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_addr_r;
        mem_wdata = hit_word_r | alloc_iso;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re    = issue;
  assign mem_raddr = rd_addr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (init_addr_r == AW'(NUM_WORDS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.req_type == bpa_pkg::REQ_ALLOC) ? S_WALK : S_DIV;
        end
      end
      S_DIV:  if (div_done) state_nxt = S_WALK;
      S_WALK: begin
        if (found) begin
          state_nxt = S_AWR;
        end else if (walk_done) begin
          state_nxt = S_FIN;
        end
      end
      S_AWR:  state_nxt = S_FIN;
      S_FIN:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_addr_r <= '0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      d_valid_r <= issue;
      if (state_r == S_INIT) begin
        init_addr_r <= init_addr_r + AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r     <= in_data.req_type;
      first_r    <= in_data.page_index;
      page_r     <= '0;
      div_q_r    <= '0;
      div_cnt_r  <= 1'b0;
      if (in_data.req_type == bpa_pkg::REQ_ALLOC) begin
        status_r     <= bpa_pkg::ST_DONE;
        end_r        <= PGW'(LIMIT);
        rd_addr_r    <= '0;
        rd_base_r    <= '0;
        first_word_r <= '0;
        first_bit_r  <= '0;
      end else begin
        status_r <= (req_sum > EW'(NUM_PAGES)) ? bpa_pkg::ST_RANGE : bpa_pkg::ST_DONE;
        end_r    <= req_end;
      end
    end
    if (state_r == S_DIV) begin
      div_q_r   <= div_quo;
      div_cnt_r <= 1'b1;
      if (div_done) begin
        first_word_r <= AW'(q_fin);
        first_bit_r  <= rem_fin;
        rd_addr_r    <= AW'(q_fin);
        rd_base_r    <= PGW'(first_r) - PGW'(rem_fin);
      end
    end
    if (issue) begin
      rd_addr_r <= rd_addr_r + AW'(1);
      rd_base_r <= rd_base_r + PGW'(WORD_BITS);
      d_addr_r  <= rd_addr_r;
      d_base_r  <= rd_base_r;
    end
    if (found) begin
      hit_word_r <= rd_data_r;
      hit_free_r <= free_bits;
      hit_addr_r <= d_addr_r;
      hit_base_r <= d_base_r[PW-1:0];
    end
    if ((state_r == S_WALK) && !found && walk_done && (kind_r == bpa_pkg::REQ_ALLOC)) begin
      status_r <= bpa_pkg::ST_NO_FREE;
    end
    if (state_r == S_AWR) begin
      page_r <= hit_base_r + PW'(alloc_bit);
    end
    if (out_load) begin
      out_data_r.result_page <= page_r;
      out_data_r.status      <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The write-back of one word never lands on the word being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("bitmap read and write hit the same word");

  // Every word in flight lies below the end of the walk.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r |-> (d_base_r < end_r))
    else $error("walk read past its end");

  // A finished request reaches the output register once the slot is free.
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && (!out_valid_r || !out_stall)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded");

  // Only a successful allocate hands out a non-zero page.
  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != bpa_pkg::ST_DONE)) |-> (out_data_r.result_page == '0))
    else $error("page reported with failing status");

  // No request is taken during the clearing pass.
  a_init_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |=> (!$past(in_acc) && !d_valid_r))
    else $error("request taken during clearing pass");

endmodule

[test/tb_bitmap_page_allocator.sv]
// Self-checking testbench for the bitmap page allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator;

  localparam int N_PAGES    = bpa_pkg::NUM_PAGES_DEF;
  localparam int WBITS      = bpa_pkg::WORD_BITS_DEF;
  localparam int PAGE_W     = bpa_pkg::PAGE_W;
  localparam int COUNT_W    = bpa_pkg::COUNT_W;
  localparam int N_WORDS    = (N_PAGES + WBITS - 1) / WBITS;
  localparam int WIDX_W     = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
  localparam int BIT_W      = $clog2(WBITS);
  localparam int SCAN_LIMIT = (N_PAGES < bpa_pkg::RESULT_PAGE_LIMIT) ?
                              N_PAGES : bpa_pkg::RESULT_PAGE_LIMIT;
  localparam int SCAN_WORDS = (SCAN_LIMIT + WBITS - 1) / WBITS;
  localparam int WIN_PAGES  = 4096;   // most random traffic stays in this low window
  localparam int PHASE_BEATS = 382;
  localparam int N_DIRECTED = 25;

  typedef struct packed {
    logic          typed;
    bpa_pkg::req_t req;
    bpa_pkg::rsp_t rsp;
  } dir_row_t;

  // Rows with typed set carry the response as written; the rest go through the predictor.
  localparam dir_row_t DIRECTED_TAB [N_DIRECTED] = '{
    '{1'b1, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_NO_FREE}},
    '{1'b1, '{bpa_pkg::REQ_FREE,      16'hFFFF, 17'h1FFFF}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_ALLOC,     16'hFFFF, 17'h00000}, '{16'hFFFF, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_NO_FREE}},
    '{1'b1, '{bpa_pkg::REQ_MARK_FREE, 16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_NO_FREE}},
    '{1'b1, '{bpa_pkg::REQ_MARK_FREE, 16'h0000, 17'h10000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b0, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_MARK_USED, 16'hFFFF, 17'h1FFFF}, '{16'h0000, bpa_pkg::ST_RANGE}},
    '{1'b1, '{bpa_pkg::REQ_MARK_USED, 16'h0000, 17'h10000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_FREE,      16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_FREE,      16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_MARK_USED, 16'h0005, 17'h00003}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_MARK_FREE, 16'h8000, 17'h10000}, '{16'h0000, bpa_pkg::ST_RANGE}},
    '{1'b1, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h8000, bpa_pkg::ST_DONE}},
    '{1'b0, '{bpa_pkg::REQ_FREE,      16'h1234, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b0, '{bpa_pkg::REQ_MARK_FREE, 16'h0064, 17'h00040}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b0, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b0, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_MARK_USED, 16'h0000, 17'h10000}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b1, '{bpa_pkg::REQ_MARK_FREE, 16'h0000, 17'd4096},  '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b0, '{bpa_pkg::REQ_MARK_USED, 16'h00C0, 17'h00007}, '{16'h0000, bpa_pkg::ST_DONE}},
    '{1'b0, '{bpa_pkg::REQ_ALLOC,     16'h0000, 17'h00000}, '{16'h0000, bpa_pkg::ST_DONE}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bpa_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bpa_pkg::rsp_t out_data;

  logic [WBITS-1:0] page_used [N_WORDS];
  bpa_pkg::rsp_t rsp_q [$];
  int   taken_pages [$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   mismatches = 0;
  int   n_req [4] = '{0, 0, 0, 0};
  int   n_status [4] = '{0, 0, 0, 0};
  bpa_pkg::rsp_t want;

  bitmap_page_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic void set_page_bit(int p, logic v);
    page_used[WIDX_W'(p / WBITS)][BIT_W'(p % WBITS)] = v;
  endfunction

  // Apply one request to the page map and return the response it should give.
  function automatic bpa_pkg::rsp_t apply_page_request(bpa_pkg::req_t r);
    bpa_pkg::rsp_t o;
    bit found;
    int last;
    int p;
    o = '0;
    o.status = bpa_pkg::ST_DONE;
    found = 1'b0;
    case (r.req_type)
      bpa_pkg::REQ_ALLOC: begin
        for (int w = 0; w < SCAN_WORDS && !found; w++) begin
          if (page_used[WIDX_W'(w)] != '1) begin
            for (int b = 0; b < WBITS && !found; b++) begin
              if (w * WBITS + b < SCAN_LIMIT && !page_used[WIDX_W'(w)][BIT_W'(b)]) begin
                set_page_bit(w * WBITS + b, 1'b1);
                o.result_page = PAGE_W'(w * WBITS + b);
                found = 1'b1;
              end
            end
          end
        end
        if (!found) o.status = bpa_pkg::ST_NO_FREE;
      end
      bpa_pkg::REQ_FREE: begin
        if (int'(r.page_index) < N_PAGES)
          set_page_bit(int'(r.page_index), 1'b0);
        else
          o.status = bpa_pkg::ST_RANGE;
      end
      default: begin
        last = int'(r.page_index) + int'(r.page_count);
        if (last > N_PAGES) begin
          last = N_PAGES;
          o.status = bpa_pkg::ST_RANGE;
        end
        for (p = int'(r.page_index); p < last; p++)
          set_page_bit(p, r.req_type == bpa_pkg::REQ_MARK_USED);
      end
    endcase
    return o;
  endfunction

  function automatic int idle_gap();
    int n;
    n = 0;
    while (n < 40 && $urandom_range(0, 99) < send_idle_pct) n++;
    return n;
  endfunction

  // Mostly allocates, frees of pages handed out earlier and short runs in the low window;
  // now and then a run anywhere with any length.
  function automatic bpa_pkg::req_t random_request();
    bpa_pkg::req_t r;
    int pick;
    int k;
    r.req_type   = bpa_pkg::REQ_ALLOC;
    r.page_index = PAGE_W'($urandom);
    r.page_count = COUNT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.req_type = bpa_pkg::REQ_ALLOC;
    end else if (pick < 65) begin
      r.req_type = bpa_pkg::REQ_FREE;
      if (taken_pages.size() > 0 && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, taken_pages.size() - 1);
        r.page_index = PAGE_W'(taken_pages[k]);
        taken_pages.delete(k);
      end else if ($urandom_range(0, 9) < 8) begin
        r.page_index = PAGE_W'($urandom_range(0, WIN_PAGES - 1));
      end
    end else if (pick < 80) begin
      r.req_type   = bpa_pkg::REQ_MARK_FREE;
      r.page_index = PAGE_W'($urandom_range(0, WIN_PAGES - 1));
      r.page_count = COUNT_W'($urandom_range(0, 200));
    end else if (pick < 96) begin
      r.req_type   = bpa_pkg::REQ_MARK_USED;
      r.page_index = PAGE_W'($urandom_range(0, WIN_PAGES - 1));
      r.page_count = COUNT_W'($urandom_range(0, 128));
    end else begin
      r.req_type   = $urandom_range(0, 1) ? bpa_pkg::REQ_MARK_FREE : bpa_pkg::REQ_MARK_USED;
      r.page_count = COUNT_W'($urandom_range(0, 131071));
    end
    return r;
  endfunction

  // Drive one beat from a falling edge, hold it until taken, return at the next falling edge.
  task automatic send_request(input bpa_pkg::req_t r, input logic typed,
                              input bpa_pkg::rsp_t typed_rsp);
    int gap;
    bpa_pkg::rsp_t predicted;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_page_request(r);
    if (r.req_type == bpa_pkg::REQ_ALLOC && predicted.status == bpa_pkg::ST_DONE)
      taken_pages.push_back(int'(predicted.result_page));
    rsp_q.push_back(typed ? typed_rsp : predicted);
    n_req[r.req_type]++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_status[out_data.status]++;
      if (rsp_q.size() == 0) begin
        $error("result beat with nothing expected: page %0d status %0d",
               out_data.result_page, out_data.status);
        mismatches++;
      end else begin
        want = rsp_q.pop_front();
        if (out_data.result_page !== want.result_page) begin
          $error("result_page: expected %0d, got %0d", want.result_page, out_data.result_page);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (int w = 0; w < N_WORDS; w++) page_used[WIDX_W'(w)] = '1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_TAB[i])
      send_request(DIRECTED_TAB[i].req, DIRECTED_TAB[i].typed, DIRECTED_TAB[i].rsp);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int i = 0; i < PHASE_BEATS; i++)
        send_request(random_request(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then wait for any stray beat
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Requests sent: %0d allocate, %0d free, %0d range free, %0d range used",
             n_req[bpa_pkg::REQ_ALLOC], n_req[bpa_pkg::REQ_FREE],
             n_req[bpa_pkg::REQ_MARK_FREE], n_req[bpa_pkg::REQ_MARK_USED]);
    $display("Responses seen: %0d done, %0d no free page, %0d out of range",
             n_status[bpa_pkg::ST_DONE], n_status[bpa_pkg::ST_NO_FREE],
             n_status[bpa_pkg::ST_RANGE]);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #500ms;
    $display("Timeout: %0d responses still outstanding", rsp_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
